/* hdl/rtrt_pkg.sv */
// Package for the region table read translator.
// Holds shared types, codes and default sizes; no dependencies.
`default_nettype none

package rtrt_pkg;

  localparam int unsigned MAX_REGIONS_DEF = 1024;
  localparam int unsigned MAX_CHUNKS_DEF  = 16;

  localparam int unsigned BASE_W   = 64;
  localparam int unsigned LEN_W    = 48;
  localparam int unsigned OFF_W    = 48;
  localparam int unsigned RLEN_W   = 32;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 48;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKING_SIZE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOAD_REJ = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FRAG     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CORRUPT  = 3'd5;

  typedef struct packed {
    logic              valid;
    logic [BASE_W-1:0] base;
    logic [LEN_W-1:0]  length;
    logic [OFF_W-1:0]  offset;
  } region_entry_t;

  typedef struct packed {
    logic [OFF_W-1:0]  offset;
    logic [RLEN_W-1:0] length;
  } chunk_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

`default_nettype wire

/* hdl/rtrt_region_mem.sv */
// Region table memory: one entry per region, valid bit held in the word.
// Single port, registered read data. Depends on rtrt_pkg.
`default_nettype none

module rtrt_region_mem #(
  parameter int unsigned MAX_REGIONS = rtrt_pkg::MAX_REGIONS_DEF,
  parameter int unsigned RA_W        = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1
) (
  input  wire                      clk,
  input  rtrt_pkg::mem_cmd_t       cmd,
  input  wire [RA_W-1:0]           addr,
  input  rtrt_pkg::region_entry_t  wdata,
  output rtrt_pkg::region_entry_t  rdata
);

  rtrt_pkg::region_entry_t mem_r [MAX_REGIONS];
  rtrt_pkg::region_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem_r[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/rtrt_chunk_buf.sv */
// Chunk buffer: holds the chunks of one read until all are known good.
// Separate write and read addresses, registered read data. Depends on rtrt_pkg.
`default_nettype none

module rtrt_chunk_buf #(
  parameter int unsigned MAX_CHUNKS = rtrt_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned CB_AW      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
  input  wire                 clk,
  input  rtrt_pkg::mem_cmd_t  cmd,
  input  wire [CB_AW-1:0]     waddr,
  input  rtrt_pkg::chunk_t    wdata,
  input  wire [CB_AW-1:0]     raddr,
  output rtrt_pkg::chunk_t    rdata
);

  rtrt_pkg::chunk_t buf_r [MAX_CHUNKS];
  rtrt_pkg::chunk_t rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      buf_r[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= buf_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/rtrt_seq.sv */
// Sequencer: clearing pass, loads, table scan per chunk, chunk emission
// and the output register. Drives rtrt_region_mem and rtrt_chunk_buf; uses rtrt_pkg.
`default_nettype none

module rtrt_seq #(
  parameter int unsigned MAX_REGIONS = rtrt_pkg::MAX_REGIONS_DEF,
  parameter int unsigned MAX_CHUNKS  = rtrt_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned RA_W        = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1,
  parameter int unsigned CB_AW       = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire [rtrt_pkg::COUNT_W-1:0]       region_count,
  input  wire [rtrt_pkg::LEN_W-1:0]         backing_size,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_opcode,
  input  wire [rtrt_pkg::INDEX_W-1:0]       in_entry_index,
  input  wire [rtrt_pkg::BASE_W-1:0]        in_entry_base,
  input  wire [rtrt_pkg::LEN_W-1:0]         in_entry_length,
  input  wire [rtrt_pkg::OFF_W-1:0]         in_entry_backing_offset,
  input  wire [rtrt_pkg::BASE_W-1:0]        in_read_address,
  input  wire [rtrt_pkg::RLEN_W-1:0]        in_read_length,
  // result channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [rtrt_pkg::STATUS_W-1:0]     out_status,
  output logic [rtrt_pkg::OFF_W-1:0]        out_backing_offset,
  output logic [rtrt_pkg::RLEN_W-1:0]       out_chunk_length,
  output logic                              out_last,
  // region table
  output rtrt_pkg::mem_cmd_t                reg_cmd,
  output logic [RA_W-1:0]                   reg_addr,
  output rtrt_pkg::region_entry_t           reg_wdata,
  input  rtrt_pkg::region_entry_t           reg_rdata,
  // chunk buffer
  output rtrt_pkg::mem_cmd_t                cb_cmd,
  output logic [CB_AW-1:0]                  cb_waddr,
  output rtrt_pkg::chunk_t                  cb_wdata,
  output logic [CB_AW-1:0]                  cb_raddr,
  input  rtrt_pkg::chunk_t                  cb_rdata
);

  localparam int unsigned LIM_W = $clog2(MAX_REGIONS + 1);
  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_LOAD    = 10'b0000000100,
    S_READ    = 10'b0000001000,
    S_CHECK   = 10'b0000010000,
    S_SCAN    = 10'b0000100000,
    S_CALC    = 10'b0001000000,
    S_EMIT_RD = 10'b0010000000,
    S_EMIT_WR = 10'b0100000000,
    S_SINGLE  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [RA_W-1:0]                 clr_idx_r, clr_idx_nxt;
  logic                            corrupt_r, corrupt_nxt;
  logic [rtrt_pkg::INDEX_W-1:0]    idx_r, idx_nxt;
  logic [rtrt_pkg::BASE_W-1:0]     ebase_r, ebase_nxt;
  logic [rtrt_pkg::LEN_W-1:0]      elen_r, elen_nxt;
  logic [rtrt_pkg::OFF_W-1:0]      eoff_r, eoff_nxt;
  logic [rtrt_pkg::BASE_W-1:0]     cur_r, cur_nxt;
  logic [rtrt_pkg::RLEN_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]                n_r, n_nxt;
  logic [CNT_W-1:0]                k_r, k_nxt;
  logic [LIM_W-1:0]                scan_idx_r, scan_idx_nxt;
  logic                            pend_r, pend_nxt;
  logic [rtrt_pkg::LEN_W-1:0]      loc_r, loc_nxt;
  logic [rtrt_pkg::LEN_W-1:0]      hlen_r, hlen_nxt;
  logic [rtrt_pkg::OFF_W-1:0]      hoff_r, hoff_nxt;
  logic [rtrt_pkg::STATUS_W-1:0]   single_st_r, single_st_nxt;

  logic                            out_vld_r, out_vld_nxt;
  logic [rtrt_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [rtrt_pkg::OFF_W-1:0]      out_off_r, out_off_nxt;
  logic [rtrt_pkg::RLEN_W-1:0]     out_len_r, out_len_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [31:0]                     count32;
  logic [LIM_W-1:0]                limit;
  logic                            out_free;
  logic                            idx_ok;
  logic                            load_rej;
  logic [rtrt_pkg::LEN_W:0]        end_sum;
  logic                            issue;
  logic [rtrt_pkg::BASE_W-1:0]     diff;
  logic                            hit;
  logic [rtrt_pkg::LEN_W-1:0]      avail;
  logic [rtrt_pkg::RLEN_W-1:0]     take;
  logic                            k_last;

  // entries beyond the table are never searched
  assign count32 = 32'(region_count);
  assign limit   = (count32 > 32'(MAX_REGIONS)) ? LIM_W'(MAX_REGIONS) : LIM_W'(count32);

  assign out_free = !out_vld_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign idx_ok   = (32'(idx_r) < 32'(MAX_REGIONS));
  assign end_sum  = {1'b0, eoff_r} + {1'b0, elen_r};
  assign load_rej = !idx_ok || (elen_r == '0) || (end_sum > {1'b0, backing_size});

  assign issue = (scan_idx_r < limit);
  assign diff  = cur_r - reg_rdata.base;
  assign hit   = reg_rdata.valid && (cur_r >= reg_rdata.base) &&
                 (diff < {16'b0, reg_rdata.length});

  assign avail  = hlen_r - loc_r;
  assign take   = (avail < {16'b0, rem_r}) ? avail[rtrt_pkg::RLEN_W-1:0] : rem_r;
  assign k_last = ((k_r + CNT_W'(1)) == n_r);

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    corrupt_nxt    = corrupt_r;
    idx_nxt        = idx_r;
    ebase_nxt      = ebase_r;
    elen_nxt       = elen_r;
    eoff_nxt       = eoff_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    scan_idx_nxt   = scan_idx_r;
    pend_nxt       = 1'b0;
    loc_nxt        = loc_r;
    hlen_nxt       = hlen_r;
    hoff_nxt       = hoff_r;
    single_st_nxt  = single_st_r;

    out_vld_nxt    = out_vld_r && out_stall;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    reg_cmd        = '0;
    reg_addr       = scan_idx_r[RA_W-1:0];
    reg_wdata      = '{valid: 1'b0, base: ebase_r, length: elen_r, offset: eoff_r};
    cb_cmd         = '0;
    cb_waddr       = n_r[CB_AW-1:0];
    cb_wdata       = '{offset: hoff_r + loc_r, length: take};
    cb_raddr       = k_r[CB_AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        // invalidate one entry a cycle
        reg_cmd.wr  = 1'b1;
        reg_addr    = clr_idx_r;
        clr_idx_nxt = clr_idx_r + RA_W'(1);
        if (clr_idx_r == RA_W'(MAX_REGIONS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt   = in_entry_index;
          ebase_nxt = in_entry_base;
          elen_nxt  = in_entry_length;
          eoff_nxt  = in_entry_backing_offset;
          cur_nxt   = in_read_address;
          rem_nxt   = in_read_length;
          n_nxt     = '0;
          state_nxt = (in_opcode == rtrt_pkg::OP_LOAD) ? S_LOAD : S_READ;
        end
      end
      S_LOAD: begin
        reg_addr        = RA_W'(idx_r);
        reg_cmd.wr      = idx_ok;
        reg_wdata.valid = !load_rej;
        if (load_rej) begin
          corrupt_nxt   = 1'b1;
          single_st_nxt = rtrt_pkg::ST_LOAD_REJ;
        end else begin
          single_st_nxt = rtrt_pkg::ST_OK;
        end
        state_nxt = S_SINGLE;
      end
      S_READ: begin
        if (corrupt_r) begin
          single_st_nxt = rtrt_pkg::ST_CORRUPT;
          state_nxt     = S_SINGLE;
        end else if (rem_r == '0) begin
          single_st_nxt = rtrt_pkg::ST_ZERO_LEN;
          state_nxt     = S_SINGLE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rem_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else if (n_r == CNT_W'(MAX_CHUNKS)) begin
          single_st_nxt = rtrt_pkg::ST_FRAG;
          state_nxt     = S_SINGLE;
        end else begin
          scan_idx_nxt = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // read ahead one entry while the previous one is compared
        reg_cmd.rd = issue;
        if (issue) begin
          scan_idx_nxt = scan_idx_r + LIM_W'(1);
        end
        pend_nxt = issue;
        if (pend_r && hit) begin
          loc_nxt   = diff[rtrt_pkg::LEN_W-1:0];
          hlen_nxt  = reg_rdata.length;
          hoff_nxt  = reg_rdata.offset;
          pend_nxt  = 1'b0;
          state_nxt = S_CALC;
        end else if (!issue) begin
          single_st_nxt = rtrt_pkg::ST_UNMAPPED;
          pend_nxt      = 1'b0;
          state_nxt     = S_SINGLE;
        end
      end
      S_CALC: begin
        cb_cmd.wr = 1'b1;
        cur_nxt   = cur_r + rtrt_pkg::BASE_W'(take);
        rem_nxt   = rem_r - take;
        n_nxt     = n_r + CNT_W'(1);
        state_nxt = S_CHECK;
      end
      S_EMIT_RD: begin
        cb_cmd.rd = 1'b1;
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = rtrt_pkg::ST_OK;
          out_off_nxt    = cb_rdata.offset;
          out_len_nxt    = cb_rdata.length;
          out_last_nxt   = k_last;
          k_nxt          = k_r + CNT_W'(1);
          state_nxt      = k_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = single_st_r;
          out_off_nxt    = '0;
          out_len_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      corrupt_r <= 1'b0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      corrupt_r <= corrupt_nxt;
      pend_r    <= pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    ebase_r      <= ebase_nxt;
    elen_r       <= elen_nxt;
    eoff_r       <= eoff_nxt;
    cur_r        <= cur_nxt;
    rem_r        <= rem_nxt;
    n_r          <= n_nxt;
    k_r          <= k_nxt;
    scan_idx_r   <= scan_idx_nxt;
    loc_r        <= loc_nxt;
    hlen_r       <= hlen_nxt;
    hoff_r       <= hoff_nxt;
    single_st_r  <= single_st_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_status_r;
  assign out_backing_offset = out_off_r;
  assign out_chunk_length   = out_len_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

/* hdl/region_table_read_translator_unit.sv */
// Region table read translator: top level with configuration registers.
// Instantiates rtrt_seq, rtrt_region_mem and rtrt_chunk_buf; uses rtrt_pkg.
//
// Input channel (in_valid / in_stall): a load word (opcode 0) writes one
// table entry and gives one result with status ok or load rejected. A read
// word (opcode 1) gives one result per chunk, last set on the final one, or
// a single error result (corrupt, zero length, unmapped, too fragmented).
// Result channel (out_valid / out_stall): one output register; a stalled
// word holds until taken, and the block waits while it is full.
// Flow: one word is worked on at a time. Each chunk of a read scans the
// table from entry 0 through the single region memory port, one entry a
// cycle, up to min(region_count, MAX_REGIONS) entries; every chunk is then
// read back from the chunk buffer.
// Reset: rst_n clears control state and the configuration registers, then a
// clearing pass invalidates every entry; in_stall is high throughout.
// Configuration writes are taken at any time.
`default_nettype none

module region_table_read_translator_unit #(
  parameter int unsigned MAX_REGIONS = rtrt_pkg::MAX_REGIONS_DEF,
  parameter int unsigned MAX_CHUNKS  = rtrt_pkg::MAX_CHUNKS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // configuration
  input  wire                                cfg_we,
  input  wire [rtrt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [rtrt_pkg::CFG_DAT_W-1:0]      cfg_wdata,
  // input channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_opcode,
  input  wire [rtrt_pkg::INDEX_W-1:0]        in_entry_index,
  input  wire [rtrt_pkg::BASE_W-1:0]         in_entry_base,
  input  wire [rtrt_pkg::LEN_W-1:0]          in_entry_length,
  input  wire [rtrt_pkg::OFF_W-1:0]          in_entry_backing_offset,
  input  wire [rtrt_pkg::BASE_W-1:0]         in_read_address,
  input  wire [rtrt_pkg::RLEN_W-1:0]         in_read_length,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [rtrt_pkg::STATUS_W-1:0]      out_status,
  output logic [rtrt_pkg::OFF_W-1:0]         out_backing_offset,
  output logic [rtrt_pkg::RLEN_W-1:0]        out_chunk_length,
  output logic                               out_last
);

  localparam int unsigned RA_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CB_AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  logic [rtrt_pkg::COUNT_W-1:0] region_count_r;
  logic [rtrt_pkg::LEN_W-1:0]   backing_size_r;

  rtrt_pkg::mem_cmd_t      reg_cmd;
  logic [RA_W-1:0]         reg_addr;
  rtrt_pkg::region_entry_t reg_wdata;
  rtrt_pkg::region_entry_t reg_rdata;
  rtrt_pkg::mem_cmd_t      cb_cmd;
  logic [CB_AW-1:0]        cb_waddr;
  logic [CB_AW-1:0]        cb_raddr;
  rtrt_pkg::chunk_t        cb_wdata;
  rtrt_pkg::chunk_t        cb_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= '0;
      backing_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtrt_pkg::CFG_REGION_COUNT: region_count_r <= cfg_wdata[rtrt_pkg::COUNT_W-1:0];
        rtrt_pkg::CFG_BACKING_SIZE: backing_size_r <= cfg_wdata[rtrt_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  rtrt_seq #(
    .MAX_REGIONS (MAX_REGIONS),
    .MAX_CHUNKS  (MAX_CHUNKS),
    .RA_W        (RA_W),
    .CB_AW       (CB_AW)
  ) u_seq (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .region_count            (region_count_r),
    .backing_size            (backing_size_r),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_opcode               (in_opcode),
    .in_entry_index          (in_entry_index),
    .in_entry_base           (in_entry_base),
    .in_entry_length         (in_entry_length),
    .in_entry_backing_offset (in_entry_backing_offset),
    .in_read_address         (in_read_address),
    .in_read_length          (in_read_length),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_backing_offset      (out_backing_offset),
    .out_chunk_length        (out_chunk_length),
    .out_last                (out_last),
    .reg_cmd                 (reg_cmd),
    .reg_addr                (reg_addr),
    .reg_wdata               (reg_wdata),
    .reg_rdata               (reg_rdata),
    .cb_cmd                  (cb_cmd),
    .cb_waddr                (cb_waddr),
    .cb_wdata                (cb_wdata),
    .cb_raddr                (cb_raddr),
    .cb_rdata                (cb_rdata)
  );

  rtrt_region_mem #(
    .MAX_REGIONS (MAX_REGIONS),
    .RA_W        (RA_W)
  ) u_region_mem (
    .clk   (clk),
    .cmd   (reg_cmd),
    .addr  (reg_addr),
    .wdata (reg_wdata),
    .rdata (reg_rdata)
  );

  rtrt_chunk_buf #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .CB_AW      (CB_AW)
  ) u_chunk_buf (
    .clk   (clk),
    .cmd   (cb_cmd),
    .waddr (cb_waddr),
    .wdata (cb_wdata),
    .raddr (cb_raddr),
    .rdata (cb_rdata)
  );

endmodule

`default_nettype wire
